FILE: hw/rtl/owbm_pkg.sv
// Shared types and constants for the one-wire bus master.
// No dependencies; every other file in hw/rtl imports this package.
package owbm_pkg;

    localparam int COUNTER_BITS_DEF = 12;
    localparam int CFG_W            = 12;
    localparam int CFG_IDX_W        = 3;
    localparam int NUM_REGS         = 8;
    localparam int OP_W             = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_SMP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_REC      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LOW       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SMP       = 3'd7;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_RESET_LOW      = 12'd500;
    localparam logic [CFG_W-1:0] RST_PRESENCE_SMP   = 12'd70;
    localparam logic [CFG_W-1:0] RST_RESET_REC      = 12'd1000;
    localparam logic [CFG_W-1:0] RST_WRITE_ONE_LOW  = 12'd6;
    localparam logic [CFG_W-1:0] RST_WRITE_ZERO_LOW = 12'd60;
    localparam logic [CFG_W-1:0] RST_SLOT           = 12'd70;
    localparam logic [CFG_W-1:0] RST_READ_LOW       = 12'd6;
    localparam logic [CFG_W-1:0] RST_READ_SMP       = 12'd15;

    // Dallas CRC-8, reflected form of x^8+x^5+x^4+1
    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_RESET      = 3'd1,
        OP_WRITE_BYTE = 3'd2,
        OP_READ_BYTE  = 3'd3,
        OP_READ_BIT   = 3'd4,
        OP_CLEAR_CRC  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_REC  = 3'd3,
        PH_SLOT     = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        K_RESET     = 2'd0,
        K_WRITE     = 2'd1,
        K_READ_BYTE = 2'd2,
        K_READ_BIT  = 2'd3
    } t_kind;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_value;
        logic [7:0] crc_value;
        logic       rejected;
    } t_result;

endpackage

FILE: hw/rtl/owbm_in_if.sv
// Command/tick input channel of the one-wire bus master.
// Depends on owbm_pkg for the field widths.
interface owbm_in_if
    import owbm_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    logic [7:0]      write_value;
    logic            line_sample;

    modport source (output valid, output operation, output write_value,
                    output line_sample, input ready);
    modport sink   (input valid, input operation, input write_value,
                    input line_sample, output ready);
endinterface

FILE: hw/rtl/owbm_out_if.sv
// Result channel of the one-wire bus master.
// Depends on owbm_pkg (no types used beyond plain widths).
interface owbm_out_if
    import owbm_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_value;
    logic [7:0] crc_value;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_value, output crc_value,
                    output rejected, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input read_value, input crc_value,
                    input rejected, output ready);
endinterface

FILE: hw/rtl/owbm_cfg_if.sv
// Configuration write channel of the one-wire bus master.
// Depends on owbm_pkg for index and data widths.
interface owbm_cfg_if
    import owbm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: hw/rtl/one_wire_bus_master.sv
// One-wire bus master with running Dallas CRC-8, stepped by tick transactions.
// Depends on owbm_pkg and the interfaces owbm_in_if, owbm_out_if, owbm_cfg_if.
//
//  channel  dir  contents                                  handshake
//  i_in     in   operation, write_value, line_sample       valid/ready
//  o_out    out  drive_low, busy_res, done_res, presence,  valid/ready
//                read_value, crc_value, rejected
//  i_cfg    in   reg_index, wr_data                        valid/ready (always ready)
//
// Every input transaction is processed combinationally; its result lands in the
// output register on the same edge. One transaction per cycle is sustained;
// i_in.ready is high whenever the output register is empty or being drained.
// Synchronous active-low reset clears the sequencer and loads default timings.
// A stall on o_out holds the result and stalls i_in; there is no other wait.
module one_wire_bus_master
    import owbm_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    owbm_in_if.sink     i_in,
    owbm_out_if.source  o_out,
    owbm_cfg_if.sink    i_cfg
);

    localparam int LW = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;
    localparam logic [LW-1:0] CntMax = LW'({COUNTER_BITS{1'b1}});

    // zero acts as one tick, anything past the counter range as its maximum
    function automatic logic [LW-1:0] lim_f(input logic [CFG_W-1:0] x);
        logic [LW-1:0] xe;
        xe = LW'(x);
        if (x == '0) begin
            return LW'(1);
        end
        if (xe > CntMax) begin
            return CntMax;
        end
        return xe;
    endfunction

    logic [CFG_W-1:0] r_cfg [NUM_REGS];

    t_phase                  r_phase, n_phase;
    t_kind                   r_kind, n_kind;
    logic [COUNTER_BITS-1:0] r_tick_count, n_tick_count;
    logic [3:0]              r_bit_index, n_bit_index;
    logic [7:0]              r_shift, n_shift;
    logic [7:0]              r_recv, n_recv;
    logic                    r_presence, n_presence;
    logic [7:0]              r_crc, n_crc;

    logic    r_out_valid;
    t_result r_out, n_res;

    logic                    in_accept;
    logic                    done, rej;
    logic [COUNTER_BITS-1:0] t_next;
    logic [LW-1:0]           t_next_e;
    logic [CFG_W-1:0]        read_smp;
    logic [3:0]              bi_inc;
    logic [3:0]              bit_total;
    logic                    smp_bit;
    logic [CFG_W-1:0]        low_time;

    assign in_accept   = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    assign t_next   = (r_tick_count == '1) ? r_tick_count : r_tick_count + 1'b1;
    assign t_next_e = LW'(t_next);
    assign read_smp = (r_cfg[REG_READ_SMP] < r_cfg[REG_SLOT]) ? r_cfg[REG_READ_SMP]
                                                              : r_cfg[REG_SLOT];
    assign bi_inc    = r_bit_index + 4'd1;
    assign bit_total = (r_kind == K_READ_BIT) ? 4'd1 : 4'd8;
    assign smp_bit   = i_in.line_sample;

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_tick_count = r_tick_count;
        n_bit_index  = r_bit_index;
        n_shift      = r_shift;
        n_recv       = r_recv;
        n_presence   = r_presence;
        n_crc        = r_crc;
        done         = 1'b0;
        rej          = 1'b0;
        case (i_in.operation)
            OP_RESET, OP_WRITE_BYTE, OP_READ_BYTE, OP_READ_BIT, OP_CLEAR_CRC: begin
                if (r_phase != PH_IDLE) begin
                    rej = 1'b1;
                end else if (i_in.operation == OP_RESET) begin
                    n_phase      = PH_RST_LOW;
                    n_kind       = K_RESET;
                    n_tick_count = '0;
                end else if (i_in.operation == OP_CLEAR_CRC) begin
                    n_crc = '0;
                    done  = 1'b1;
                end else begin
                    n_phase      = PH_SLOT;
                    n_kind       = (i_in.operation == OP_WRITE_BYTE) ? K_WRITE :
                                   (i_in.operation == OP_READ_BYTE)  ? K_READ_BYTE :
                                                                       K_READ_BIT;
                    n_shift      = (i_in.operation == OP_WRITE_BYTE) ? i_in.write_value
                                                                     : 8'd0;
                    n_tick_count = '0;
                    n_bit_index  = '0;
                end
            end
            default: begin
                // tick, including the unused codes
                case (r_phase)
                    PH_RST_LOW: begin
                        if (t_next_e >= lim_f(r_cfg[REG_RESET_LOW])) begin
                            n_phase      = PH_RST_WAIT;
                            n_tick_count = '0;
                        end else begin
                            n_tick_count = t_next;
                        end
                    end
                    PH_RST_WAIT: begin
                        if (t_next_e >= lim_f(r_cfg[REG_PRESENCE_SMP])) begin
                            n_presence   = !smp_bit;
                            n_phase      = PH_RST_REC;
                            n_tick_count = '0;
                        end else begin
                            n_tick_count = t_next;
                        end
                    end
                    PH_RST_REC: begin
                        if (t_next_e >= lim_f(r_cfg[REG_RESET_REC])) begin
                            n_phase      = PH_IDLE;
                            n_tick_count = '0;
                            done         = 1'b1;
                        end else begin
                            n_tick_count = t_next;
                        end
                    end
                    PH_SLOT: begin
                        if (r_kind != K_WRITE && t_next_e == lim_f(read_smp)) begin
                            n_shift = r_shift | (8'(smp_bit) << r_bit_index[2:0]);
                            n_crc   = {1'b0, r_crc[7:1]} ^
                                      (((r_crc[0] ^ smp_bit) == 1'b1) ? CRC_POLY : 8'd0);
                        end
                        if (t_next_e >= lim_f(r_cfg[REG_SLOT])) begin
                            n_bit_index  = bi_inc;
                            n_tick_count = '0;
                            if (bi_inc >= bit_total) begin
                                if (r_kind == K_READ_BYTE) begin
                                    n_recv = n_shift;
                                end else if (r_kind == K_READ_BIT) begin
                                    n_recv = {7'd0, n_shift[0]};
                                end
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end
                        end else begin
                            n_tick_count = t_next;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase
    end

    // outputs, from the state as it stands after this transaction
    always_comb begin
        low_time = (n_kind == K_WRITE)
                 ? (n_shift[n_bit_index[2:0]] ? r_cfg[REG_WRITE_ONE_LOW]
                                              : r_cfg[REG_WRITE_ZERO_LOW])
                 : r_cfg[REG_READ_LOW];
        n_res.drive_low  = 1'b0;
        case (n_phase)
            PH_RST_LOW: n_res.drive_low = 1'b1;
            PH_SLOT:    n_res.drive_low = LW'(n_tick_count) < lim_f(low_time);
            default:    n_res.drive_low = 1'b0;
        endcase
        n_res.busy_res   = (n_phase != PH_IDLE);
        n_res.done_res   = done;
        n_res.presence   = n_presence;
        n_res.read_value = n_recv;
        n_res.crc_value  = n_crc;
        n_res.rejected   = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_kind       <= K_RESET;
            r_tick_count <= '0;
            r_bit_index  <= '0;
            r_shift      <= '0;
            r_recv       <= '0;
            r_presence   <= 1'b0;
            r_crc        <= '0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_tick_count <= n_tick_count;
            r_bit_index  <= n_bit_index;
            r_shift      <= n_shift;
            r_recv       <= n_recv;
            r_presence   <= n_presence;
            r_crc        <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_RESET_LOW]      <= RST_RESET_LOW;
            r_cfg[REG_PRESENCE_SMP]   <= RST_PRESENCE_SMP;
            r_cfg[REG_RESET_REC]      <= RST_RESET_REC;
            r_cfg[REG_WRITE_ONE_LOW]  <= RST_WRITE_ONE_LOW;
            r_cfg[REG_WRITE_ZERO_LOW] <= RST_WRITE_ZERO_LOW;
            r_cfg[REG_SLOT]           <= RST_SLOT;
            r_cfg[REG_READ_LOW]       <= RST_READ_LOW;
            r_cfg[REG_READ_SMP]       <= RST_READ_SMP;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_cfg[i_cfg.reg_index] <= i_cfg.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.drive_low  = r_out.drive_low;
    assign o_out.busy_res   = r_out.busy_res;
    assign o_out.done_res   = r_out.done_res;
    assign o_out.presence   = r_out.presence;
    assign o_out.read_value = r_out.read_value;
    assign o_out.crc_value  = r_out.crc_value;
    assign o_out.rejected   = r_out.rejected;

    // a rejected command never touches the running one, so it is still busy
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.rejected |-> r_out.busy_res)
        else $error("rejected result while not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res && !r_out.drive_low)
        else $error("done result with bus still busy");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_tick_count == '0)
        else $error("tick counter not cleared in idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

endmodule
